// ===== rtl/core/btsc_pkg.sv =====
// Shared types and constants of the bracketed token span checker.
`timescale 1ns / 1ps
`default_nettype none

package btsc_pkg;

  // Fixed widths of the configuration registers.
  localparam int unsigned CodeW   = 16;  // open / close token registers
  localparam int unsigned LenW    = 12;  // max_length / min_length registers
  localparam int unsigned CountW  = 4;   // excluded_count register
  localparam int unsigned WordW   = 64;  // excluded token words
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_OPEN_TOKEN     = 3'd0,
    REG_CLOSE_TOKEN    = 3'd1,
    REG_MAX_LENGTH     = 3'd2,
    REG_MAX_LENGTH_EN  = 3'd3,
    REG_MIN_LENGTH     = 3'd4,
    REG_EXCL_COUNT     = 3'd5,
    REG_EXCL_LOW       = 3'd6,
    REG_EXCL_HIGH      = 3'd7
  } cfg_reg_e;

  // Reason a token was rejected.
  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_UNMATCHED = 2'd1,
    CAUSE_EXCLUDED  = 2'd2,
    CAUSE_LENGTH    = 2'd3
  } stop_cause_e;

endpackage

`default_nettype wire

// ===== rtl/core/bracketed_token_span_checker_top.sv =====
// Top level of the bracketed token span checker: config, span state and result stage.
`timescale 1ns / 1ps
`default_nettype none

// Bracketed token span checker.
// Input stream (s_axis_*): one token per request; tuser carries start_req, which
// opens a new scan at that token and drops any running scan. Output stream
// (m_axis_*): exactly one result per input request, in order, giving end_valid,
// the span length so far, a stopped flag and the stop cause.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i at the
// clock edge; write only while no request is in flight.
// Pipeline: two register stages (input register, result register); a request
// passes from the input register to the result register, which drives m_axis.
// Throughput: one request per cycle while m_axis is not stalled. The span state
// (depth, count, live flag) is updated by one pass of compare and add logic per
// request, so back-to-back requests see each other's state with no bubble.
// Stall: when m_axis_tready is low the result register holds; the input
// register takes one more request only if it is empty, then s_axis_tready drops.
// Reset (rst_ni low, asynchronous): both stages empty, depth and count zero,
// no scan running, registers at their defaults (close token 1, max length
// 4095 but disabled, no excluded slots).
module bracketed_token_span_checker_top #(
  parameter int unsigned TOKEN_BITS     = 16,
  parameter int unsigned EXCLUDED_SLOTS = 8,
  parameter int unsigned SPAN_BITS      = 12,
  localparam int unsigned InW           = ((TOKEN_BITS + 7) / 8) * 8,
  localparam int unsigned OutW          = ((SPAN_BITS + 4 + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [InW-1:0]                s_axis_tdata,   // token
  input  wire logic                          s_axis_tuser,   // start_req
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [OutW-1:0]                    m_axis_tdata,   // end_valid, span_length,
                                                             // stopped, stop_cause
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [btsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [btsc_pkg::WordW-1:0]    cfg_wdata_i
);

  localparam int unsigned CodeW  = btsc_pkg::CodeW;
  localparam int unsigned LenW   = btsc_pkg::LenW;
  localparam int unsigned WordW  = btsc_pkg::WordW;
  // compare width wide enough for both the counter and the length registers
  localparam int unsigned CmpW   = (SPAN_BITS > LenW) ? SPAN_BITS : LenW;
  localparam int unsigned SlotsPerWord = WordW / TOKEN_BITS;
  localparam int unsigned NumSlots =
    (EXCLUDED_SLOTS < 2 * SlotsPerWord) ? EXCLUDED_SLOTS : 2 * SlotsPerWord;
  localparam int unsigned SlotIdxW = 5;  // holds any slot index and count up to 16

  // ---------------------------------------------------------------- config
  logic [CodeW-1:0]              open_tok_q, close_tok_q;
  logic [LenW-1:0]               max_len_q, min_len_q;
  logic                          max_len_en_q;
  logic [btsc_pkg::CountW-1:0]   excl_cnt_q;
  logic [WordW-1:0]              excl_lo_q, excl_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_tok_q   <= '0;
      close_tok_q  <= CodeW'(1);
      max_len_q    <= '1;
      max_len_en_q <= 1'b0;
      min_len_q    <= '0;
      excl_cnt_q   <= '0;
      excl_lo_q    <= '0;
      excl_hi_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (btsc_pkg::cfg_reg_e'(cfg_index_i))
        btsc_pkg::REG_OPEN_TOKEN:    open_tok_q   <= cfg_wdata_i[CodeW-1:0];
        btsc_pkg::REG_CLOSE_TOKEN:   close_tok_q  <= cfg_wdata_i[CodeW-1:0];
        btsc_pkg::REG_MAX_LENGTH:    max_len_q    <= cfg_wdata_i[LenW-1:0];
        btsc_pkg::REG_MAX_LENGTH_EN: max_len_en_q <= cfg_wdata_i[0];
        btsc_pkg::REG_MIN_LENGTH:    min_len_q    <= cfg_wdata_i[LenW-1:0];
        btsc_pkg::REG_EXCL_COUNT:    excl_cnt_q   <= cfg_wdata_i[btsc_pkg::CountW-1:0];
        btsc_pkg::REG_EXCL_LOW:      excl_lo_q    <= cfg_wdata_i;
        btsc_pkg::REG_EXCL_HIGH:     excl_hi_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic                  in_valid_q;
  logic [TOKEN_BITS-1:0] in_tok_q;
  logic                  in_start_q;
  logic                  out_valid_q;
  logic [OutW-1:0]       out_data_q;
  logic                  advance;
  logic                  s_accept;
  logic                  step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;

  // ---------------------------------------------------------------- span logic
  logic [SPAN_BITS-1:0] depth_q, count_q;
  logic                 alive_q;

  logic [SPAN_BITS-1:0] depth_c, count_c, depth_n, count_inc;
  logic                 alive_c;
  logic [TOKEN_BITS-1:0] op_tok, cl_tok;
  logic                 is_op, is_cl, depth_zero;
  logic [NumSlots-1:0]  slot_hit;
  logic                 excl_hit;
  logic [CmpW:0]        cnt_x, depth_x, maxl_x, minl_x, left;
  logic                 lim_rej, cap_rej, unmatched, excluded, reject;
  btsc_pkg::stop_cause_e cause;
  logic                 end_ok;
  logic [SPAN_BITS-1:0] span_out;

  // compare register codes on their low TOKEN_BITS, zero-extended when the token is wider
  if (TOKEN_BITS > CodeW) begin : g_code_ext
    assign op_tok = TOKEN_BITS'(open_tok_q);
    assign cl_tok = TOKEN_BITS'(close_tok_q);
  end else begin : g_code_trunc
    assign op_tok = open_tok_q[TOKEN_BITS-1:0];
    assign cl_tok = close_tok_q[TOKEN_BITS-1:0];
  end

  // parallel match against the excluded slots in use
  for (genvar i = 0; i < NumSlots; i++) begin : g_slot
    localparam int unsigned Pos = (i % SlotsPerWord) * TOKEN_BITS;
    logic [WordW-1:0] word;
    assign word        = (i < SlotsPerWord) ? excl_lo_q : excl_hi_q;
    assign slot_hit[i] = (SlotIdxW'(i) < SlotIdxW'(excl_cnt_q)) &&
                         (word[Pos +: TOKEN_BITS] == in_tok_q);
  end
  assign excl_hit = |slot_hit;

  always_comb begin
    // a start request clears the span before the token is judged
    depth_c    = in_start_q ? '0 : depth_q;
    count_c    = in_start_q ? '0 : count_q;
    alive_c    = in_start_q || alive_q;
    is_op      = (in_tok_q == op_tok);
    is_cl      = (in_tok_q == cl_tok);
    depth_zero = (depth_c == '0);
    count_inc  = count_c + SPAN_BITS'(1);

    cnt_x   = (CmpW + 1)'(count_c);
    depth_x = (CmpW + 1)'(depth_c);
    maxl_x  = (CmpW + 1)'(max_len_q);
    minl_x  = (CmpW + 1)'(min_len_q);
    left    = maxl_x - cnt_x;

    // length limit: already full, or too few tokens left to close the brackets
    lim_rej = max_len_en_q &&
              ((cnt_x >= maxl_x) ||
               (!is_cl && ((left <= depth_x) ||
                           (is_op && (left <= depth_x + (CmpW + 1)'(1))))));
    // counter would overflow
    cap_rej = (count_c == '1);
    unmatched = is_cl && depth_zero && !is_op;
    excluded  = !is_cl && !is_op && depth_zero && excl_hit;

    priority if (!alive_c) begin
      reject = 1'b1;
      cause  = btsc_pkg::CAUSE_NONE;
    end else if (lim_rej || cap_rej) begin
      reject = 1'b1;
      cause  = btsc_pkg::CAUSE_LENGTH;
    end else if (unmatched) begin
      reject = 1'b1;
      cause  = btsc_pkg::CAUSE_UNMATCHED;
    end else if (excluded) begin
      reject = 1'b1;
      cause  = btsc_pkg::CAUSE_EXCLUDED;
    end else begin
      reject = 1'b0;
      cause  = btsc_pkg::CAUSE_NONE;
    end

    // equal open and close codes: close when nested, open at depth zero
    priority if (reject) begin
      depth_n = depth_c;
    end else if (is_cl && !depth_zero) begin
      depth_n = depth_c - SPAN_BITS'(1);
    end else if (is_cl || is_op) begin
      depth_n = depth_c + SPAN_BITS'(1);
    end else begin
      depth_n = depth_c;
    end

    span_out = reject ? count_c : count_inc;
    end_ok   = !reject && (depth_n == '0) &&
               ((min_len_q == '0) || (minl_x <= (CmpW + 1)'(count_inc)));
  end

  // hold state while the result register is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      count_q <= '0;
      alive_q <= 1'b0;
    end else if (step) begin
      depth_q <= depth_n;
      count_q <= span_out;
      alive_q <= alive_c && !reject;
    end
  end

  // ---------------------------------------------------------------- stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= s_accept || (in_valid_q && !advance);
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_tok_q   <= s_axis_tdata[TOKEN_BITS-1:0];
      in_start_q <= s_axis_tuser;
    end
    if (step) begin
      out_data_q <= OutW'({cause, reject, span_out, end_ok});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
